FILE: hw/rtl/sm3rf_pkg.sv
// Shared types, constants and round functions for the SM3 forward and inverse round block.
`timescale 1ns / 1ps

package sm3rf_pkg;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [31:0] ALL_ONES = 32'hffffffff;

   localparam int REQ_DATA_WIDTH = 112;
   localparam int RSP_DATA_WIDTH = 256;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_FORWARD = 2'd1,
      OP_INVERSE = 2'd2,
      OP_HOLD    = 2'd3
   } opcode_type;

   typedef logic [7:0][31:0] words_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [2:0]  word_index;
      logic [31:0] load_value;
      logic [31:0] msg_word;
      logic [31:0] msg_word_prime;
      logic [5:0]  round_index;
   } req_item_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] wide;
      wide = {x, x} << n;
      return wide[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm0_inv(input logic [31:0] x);
      return x ^ rotl32(x, 5'd2) ^ rotl32(x, 5'd3) ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd11)
         ^ rotl32(x, 5'd17) ^ rotl32(x, 5'd18) ^ rotl32(x, 5'd19) ^ rotl32(x, 5'd27);
   endfunction

   function automatic logic [31:0] bool_ff(input logic [5:0] r, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
      if (r < 6'd16) begin
         return x ^ y ^ z;
      end
      return (x & y) | (x & z) | (y & z);
   endfunction

   function automatic logic [31:0] bool_gg(input logic [5:0] r, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
      if (r < 6'd16) begin
         return x ^ y ^ z;
      end
      return (x & y) | ((ALL_ONES ^ x) & z);
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] r);
      logic [31:0] t;
      t = (r < 6'd16) ? T_LOW : T_HIGH;
      return rotl32(t, r[4:0]);
   endfunction

endpackage

FILE: hw/rtl/sm3rf_round.sv
// Next-state logic for one load, forward round, inverse round or hold on the eight working words.
`timescale 1ns / 1ps

module sm3rf_round (
   input  sm3rf_pkg::words_type    words_cur,
   input  sm3rf_pkg::req_item_type item,
   output sm3rf_pkg::words_type    words_nxt
);

   logic [31:0] fa12;
   logic [31:0] fss1;
   logic [31:0] fss2;
   logic [31:0] ftt1;
   logic [31:0] ftt2;
   logic [31:0] pb;
   logic [31:0] pf;
   logic [31:0] ia12;
   logic [31:0] iss1;
   logic [31:0] iss2;
   logic [31:0] pd;
   logic [31:0] ph;
   logic [31:0] rc;

   always_comb begin
      rc   = sm3rf_pkg::round_const(item.round_index);

      fa12 = sm3rf_pkg::rotl32(words_cur[0], 5'd12);
      fss1 = sm3rf_pkg::rotl32(fa12 + words_cur[4] + rc, 5'd7);
      fss2 = fss1 ^ fa12;
      ftt1 = sm3rf_pkg::bool_ff(item.round_index, words_cur[0], words_cur[1], words_cur[2])
         + words_cur[3] + fss2 + item.msg_word_prime;
      ftt2 = sm3rf_pkg::bool_gg(item.round_index, words_cur[4], words_cur[5], words_cur[6])
         + words_cur[7] + fss1 + item.msg_word;

      pb   = sm3rf_pkg::rotl32(words_cur[2], 5'd23);
      pf   = sm3rf_pkg::rotl32(words_cur[6], 5'd13);
      ia12 = sm3rf_pkg::rotl32(words_cur[1], 5'd12);
      iss1 = sm3rf_pkg::rotl32(ia12 + words_cur[5] + rc, 5'd7);
      iss2 = iss1 ^ ia12;
      pd   = words_cur[0] - item.msg_word_prime
         - sm3rf_pkg::bool_ff(item.round_index, words_cur[1], pb, words_cur[3]) - iss2;
      ph   = sm3rf_pkg::perm0_inv(words_cur[4]) - item.msg_word
         - sm3rf_pkg::bool_gg(item.round_index, words_cur[5], pf, words_cur[7]) - iss1;

      words_nxt = words_cur;
      case (item.opcode)
         sm3rf_pkg::OP_LOAD: begin
            words_nxt[item.word_index] = item.load_value;
         end
         sm3rf_pkg::OP_FORWARD: begin
            words_nxt[7] = words_cur[6];
            words_nxt[6] = sm3rf_pkg::rotl32(words_cur[5], 5'd19);
            words_nxt[5] = words_cur[4];
            words_nxt[4] = sm3rf_pkg::perm0(ftt2);
            words_nxt[3] = words_cur[2];
            words_nxt[2] = sm3rf_pkg::rotl32(words_cur[1], 5'd9);
            words_nxt[1] = words_cur[0];
            words_nxt[0] = ftt1;
         end
         sm3rf_pkg::OP_INVERSE: begin
            words_nxt[0] = words_cur[1];
            words_nxt[1] = pb;
            words_nxt[2] = words_cur[3];
            words_nxt[3] = pd;
            words_nxt[4] = words_cur[5];
            words_nxt[5] = pf;
            words_nxt[6] = words_cur[7];
            words_nxt[7] = ph;
         end
         default: begin
            words_nxt = words_cur;
         end
      endcase
   end

endmodule

FILE: hw/rtl/sm3_round_forward_inverse.sv
// Top level of the SM3 forward and inverse round block with its stream channels.
//
// Usage: the block keeps the eight SM3 working words A to H. Each transfer on the
// req_ channel carries an opcode in req_tuser: load one word, run one forward
// compression round, run one inverse round, or leave the words as they are.
// Every request yields exactly one transfer on the rsp_ channel holding all eight
// words after the operation, word A in the lowest bits of rsp_tdata.
// Flow: a request taken on the req_ channel is held in the request register; once
// the response register is empty or being read, the round logic updates the words
// and the response register together, and rsp_tvalid rises with that update.
// Throughput: one request per cycle while rsp_tready is high, set by the single
// round of adds, rotates and XORs between the request register and the word and
// response registers. When the receiver stalls, the response register holds its
// data and one more request can wait in the request register; req_tready drops
// only when both are full and rsp_tready is low.
// Reset clears all eight words to zero and empties both registers.
`timescale 1ns / 1ps

module sm3_round_forward_inverse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: word_index, load_value, msg_word, msg_word_prime,
   // round_index, zero fill.
   input  logic [sm3rf_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Fields from bit 0 up: opcode.
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0 up: word_a, word_b, word_c, word_d, word_e, word_f,
   // word_g, word_h.
   output logic [sm3rf_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   sm3rf_pkg::req_item_type req_item;
   sm3rf_pkg::req_item_type stage_item_ff;
   sm3rf_pkg::req_item_type stage_item_in;
   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   sm3rf_pkg::words_type    words_ff;
   sm3rf_pkg::words_type    words_in;
   sm3rf_pkg::words_type    round_out;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   sm3rf_pkg::words_type    rsp_data_ff;
   sm3rf_pkg::words_type    rsp_data_in;
   logic                    advance;
   logic                    fire_in;
   logic                    step;

   always_comb begin
      req_item.opcode         = sm3rf_pkg::opcode_type'(req_tuser);
      req_item.word_index     = req_tdata[2:0];
      req_item.load_value     = req_tdata[34:3];
      req_item.msg_word       = req_tdata[66:35];
      req_item.msg_word_prime = req_tdata[98:67];
      req_item.round_index    = req_tdata[104:99];
   end

   sm3rf_round u_round (
      .words_cur (words_ff),
      .item      (stage_item_ff),
      .words_nxt (round_out)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage_valid_ff || advance;
   assign fire_in    = req_tvalid && req_tready;
   assign step       = stage_valid_ff && advance;

   always_comb begin
      stage_item_in  = fire_in ? req_item : stage_item_ff;
      stage_valid_in = fire_in ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      words_in       = step ? round_out : words_ff;
      rsp_data_in    = step ? round_out : rsp_data_ff;
      rsp_valid_in   = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         words_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         words_ff       <= words_in;
      end
      stage_item_ff <= stage_item_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !stage_valid_ff && (words_ff == '0))
      else $error("Reset did not clear the words and valid flags.");

   a_rsp_matches_words : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff && (rsp_data_ff == words_ff))
      else $error("Response data differs from the updated words.");

   a_forward_shift : assert property (@(posedge clock) disable iff (reset)
      (step && stage_item_ff.opcode == sm3rf_pkg::OP_FORWARD)
      |=> (words_ff[1] == $past(words_ff[0])) && (words_ff[5] == $past(words_ff[4])))
      else $error("Forward round did not shift A into B and E into F.");

   a_inverse_shift : assert property (@(posedge clock) disable iff (reset)
      (step && stage_item_ff.opcode == sm3rf_pkg::OP_INVERSE)
      |=> (words_ff[0] == $past(words_ff[1])) && (words_ff[4] == $past(words_ff[5])))
      else $error("Inverse round did not shift B into A and F into E.");

   a_hold_keeps_words : assert property (@(posedge clock) disable iff (reset)
      (!step || stage_item_ff.opcode == sm3rf_pkg::OP_HOLD) |=> $stable(words_ff))
      else $error("Words changed without an operation that updates them.");
`endif

endmodule

FILE: tb/sv/tb_sm3_round_forward_inverse.sv
// Self-checking testbench for the SM3 forward and inverse round block.
`timescale 1ns / 1ps

module tb_sm3_round_forward_inverse;

   localparam logic [31:0] ROUND_T_EARLY = 32'h79cc4519;
   localparam logic [31:0] ROUND_T_LATE  = 32'h7a879d8a;

   class sm3_state_scoreboard;
      logic [31:0]          state_words [8];
      sm3rf_pkg::words_type expected_words_q [$];
      int error_count;
      int checked_count;
      int load_count;
      int forward_count;
      int inverse_count;
      int hold_count;

      function new();
         foreach (state_words[i]) state_words[i] = '0;
      endfunction

      function logic [31:0] rol(input logic [31:0] x, input int n);
         if (n == 0) return x;
         return (x << n) | (x >> (32 - n));
      endfunction

      function logic [31:0] diffuse(input logic [31:0] x);
         return x ^ rol(x, 9) ^ rol(x, 17);
      endfunction

      function logic [31:0] undiffuse(input logic [31:0] x);
         return x ^ rol(x, 2) ^ rol(x, 3) ^ rol(x, 9) ^ rol(x, 11) ^ rol(x, 17)
            ^ rol(x, 18) ^ rol(x, 19) ^ rol(x, 27);
      endfunction

      function logic [31:0] mix_a(input logic [5:0] r, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] z);
         if (r < 16) return x ^ y ^ z;
         return (x & y) | (x & z) | (y & z);
      endfunction

      function logic [31:0] mix_e(input logic [5:0] r, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] z);
         if (r < 16) return x ^ y ^ z;
         return (x & y) | (~x & z);
      endfunction

      function logic [31:0] step_const(input logic [5:0] r);
         return rol((r < 16) ? ROUND_T_EARLY : ROUND_T_LATE, int'(r[4:0]));
      endfunction

      function void advance_round(input logic [31:0] w, input logic [31:0] wp,
                                  input logic [5:0] r);
         logic [31:0] a12, ss1, ss2, tt1, tt2, nc, ng;
         a12 = rol(state_words[0], 12);
         ss1 = rol(a12 + state_words[4] + step_const(r), 7);
         ss2 = ss1 ^ a12;
         tt1 = mix_a(r, state_words[0], state_words[1], state_words[2]) + state_words[3]
            + ss2 + wp;
         tt2 = mix_e(r, state_words[4], state_words[5], state_words[6]) + state_words[7]
            + ss1 + w;
         nc = rol(state_words[1], 9);
         ng = rol(state_words[5], 19);
         state_words[7] = state_words[6];
         state_words[6] = ng;
         state_words[5] = state_words[4];
         state_words[4] = diffuse(tt2);
         state_words[3] = state_words[2];
         state_words[2] = nc;
         state_words[1] = state_words[0];
         state_words[0] = tt1;
      endfunction

      function void rewind_round(input logic [31:0] w, input logic [31:0] wp,
                                 input logic [5:0] r);
         logic [31:0] pa, pb, pc, pd, pe, pf, pg, ph, a12, ss1, ss2;
         pa = state_words[1];
         pb = rol(state_words[2], 23);
         pc = state_words[3];
         pe = state_words[5];
         pf = rol(state_words[6], 13);
         pg = state_words[7];
         a12 = rol(pa, 12);
         ss1 = rol(a12 + pe + step_const(r), 7);
         ss2 = ss1 ^ a12;
         pd = state_words[0] - wp - mix_a(r, pa, pb, pc) - ss2;
         ph = undiffuse(state_words[4]) - w - mix_e(r, pe, pf, pg) - ss1;
         state_words = '{pa, pb, pc, pd, pe, pf, pg, ph};
      endfunction

      function void note_request(input sm3rf_pkg::req_item_type it);
         sm3rf_pkg::words_type snapshot;
         case (it.opcode)
            sm3rf_pkg::OP_LOAD: begin
               state_words[it.word_index] = it.load_value;
               load_count++;
            end
            sm3rf_pkg::OP_FORWARD: begin
               advance_round(it.msg_word, it.msg_word_prime, it.round_index);
               forward_count++;
            end
            sm3rf_pkg::OP_INVERSE: begin
               rewind_round(it.msg_word, it.msg_word_prime, it.round_index);
               inverse_count++;
            end
            default: begin
               hold_count++;
            end
         endcase
         foreach (state_words[i]) snapshot[i] = state_words[i];
         expected_words_q.insert(expected_words_q.size(), snapshot);
      endfunction

      function void check_response(input sm3rf_pkg::words_type got);
         sm3rf_pkg::words_type want;
         if (expected_words_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("Response transfer with nothing expected: %h", got);
            return;
         end
         want = expected_words_q.pop_front();
         checked_count++;
         for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i]) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Response %0d, word %c: expected %08h, got %08h",
                           checked_count, 8'h41 + i, want[i], got[i]);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [sm3rf_pkg::REQ_DATA_WIDTH-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [sm3rf_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;

   sm3_state_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int items_sent;

   sm3_round_forward_inverse dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sm3_round_forward_inverse verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(sm3rf_pkg::words_type'(rsp_tdata));
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic sm3rf_pkg::req_item_type make_item(input sm3rf_pkg::opcode_type op,
                                                         input logic [2:0] idx,
                                                         input logic [31:0] val,
                                                         input logic [31:0] w,
                                                         input logic [31:0] wp,
                                                         input logic [5:0] r);
      sm3rf_pkg::req_item_type it;
      it.opcode = op;
      it.word_index = idx;
      it.load_value = val;
      it.msg_word = w;
      it.msg_word_prime = wp;
      it.round_index = r;
      return it;
   endfunction

   task automatic send_item(input sm3rf_pkg::req_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, it.round_index, it.msg_word_prime, it.msg_word, it.load_value,
                    it.word_index};
      req_tuser <= it.opcode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(it);
      items_sent++;
   endtask

   task automatic send_load(input logic [2:0] idx, input logic [31:0] val);
      send_item(make_item(sm3rf_pkg::OP_LOAD, idx, val, $urandom, $urandom, 6'($urandom)));
   endtask

   task automatic send_round(input sm3rf_pkg::opcode_type op, input logic [31:0] w,
                             input logic [31:0] wp, input logic [5:0] r);
      send_item(make_item(op, 3'($urandom), $urandom, w, wp, r));
   endtask

   task automatic run_directed();
      logic [31:0] seed_words [8];
      logic [5:0]  corner_rounds [6];
      logic [31:0] msg_w [6];
      logic [31:0] msg_wp [6];
      seed_words = '{32'hffffffff, 32'h80000000, 32'h00000001, 32'ha5a5a5a5,
                     32'hffffffff, 32'h5a5a5a5a, 32'h12345678, 32'hdeadbeef};
      corner_rounds = '{6'd0, 6'd15, 6'd16, 6'd31, 6'd32, 6'd63};
      msg_w  = '{32'h0, 32'h00000001, 32'hffffffff, 32'h80000000, 32'h0, 32'hffffffff};
      msg_wp = '{32'h0, 32'h80000000, 32'hffffffff, 32'h00000001, 32'hffffffff, 32'h0};
      for (int i = 0; i < 8; i++) send_load(3'(i), seed_words[i]);
      for (int i = 0; i < 6; i++) begin
         send_round(sm3rf_pkg::OP_FORWARD, msg_w[i], msg_wp[i], corner_rounds[i]);
      end
      send_item(make_item(sm3rf_pkg::OP_HOLD, 3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                          6'd63));
      for (int i = 5; i >= 0; i--) begin
         send_round(sm3rf_pkg::OP_INVERSE, msg_w[i], msg_wp[i], corner_rounds[i]);
      end
      send_load(3'd7, 32'h0);
      send_round(sm3rf_pkg::OP_FORWARD, 32'h0, 32'h0, 6'd47);
      send_round(sm3rf_pkg::OP_INVERSE, 32'h0, 32'h0, 6'd47);
   endtask

   task automatic run_round_trip();
      logic [31:0] ws [8];
      logic [31:0] wps [8];
      logic [5:0]  rs [8];
      int depth;
      int loads;
      int undo;
      loads = $urandom_range(8);
      depth = $urandom_range(1, 8);
      for (int i = 0; i < loads; i++) send_load(3'($urandom), $urandom);
      for (int i = 0; i < depth; i++) begin
         ws[i] = $urandom;
         wps[i] = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
         if (wps[i] == 32'h0) ws[i] = 32'h0;
         rs[i] = 6'($urandom);
         send_round(sm3rf_pkg::OP_FORWARD, ws[i], wps[i], rs[i]);
      end
      undo = ($urandom_range(4) == 0) ? $urandom_range(depth) : depth;
      for (int i = depth - 1; i >= depth - undo; i--) begin
         if ($urandom_range(9) == 0) begin
            send_round(sm3rf_pkg::OP_INVERSE, ws[i] ^ 32'h1, wps[i], rs[i] ^ 6'h10);
         end else begin
            send_round(sm3rf_pkg::OP_INVERSE, ws[i], wps[i], rs[i]);
         end
      end
   endtask

   task automatic run_random(input int target);
      int goal;
      int burst;
      int pick;
      goal = items_sent + target;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            run_round_trip();
         end else begin
            burst = $urandom_range(1, 6);
            for (int i = 0; i < burst; i++) begin
               send_item(make_item(sm3rf_pkg::opcode_type'($urandom_range(3)), 3'($urandom),
                                   $urandom, $urandom, $urandom, 6'($urandom)));
            end
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 16;
      recv_stall_pct = 55;
      items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(320);
      send_idle_pct = 55;
      recv_stall_pct = 16;
      run_random(330);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(330);
      req_tvalid <= 1'b0;
      while (sb.expected_words_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.expected_words_q.size() != 0) sb.error_count++;
      $display("Sent %0d transfers: %0d loads, %0d forward rounds, %0d inverse rounds, %0d holds.",
               items_sent, sb.load_count, sb.forward_count, sb.inverse_count, sb.hold_count);
      $display("Checked %0d responses across three sender and receiver idle patterns.",
               sb.checked_count);
      if (sb.error_count == 0) begin
         $display("sm3_round_forward_inverse verification clean");
      end else begin
         $display("sm3_round_forward_inverse verification failed");
      end
      $finish;
   end

endmodule
